// ===== rtl/core/sq_pkg.sv =====
// Shared types and constants for the sorted queue with remove.
package sq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned CountW       = 5;
  // Fan-in of the first level of the registered reduction tree.
  localparam int unsigned TreeGroup    = 16;
  // Word that each cell feeds into the tree: match flag over last-entry value.
  localparam int unsigned ReduceW      = KeyW + 1;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2,
    STAT_NO_MATCH  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_EXEC   = 3'd1,
    S_SETTLE = 3'd2,
    S_CHECK  = 3'd3,
    S_DONE   = 3'd4
  } state_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [KeyW-1:0]  value;
  } sq_in_t;

  typedef struct packed {
    logic signed [KeyW-1:0]  smallest;
    logic signed [KeyW-1:0]  largest;
    logic [CountW-1:0]       entry_count;
    status_e                 status;
  } sq_out_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_e                op;
    logic signed [KeyW-1:0]  key;
  } sq_ctrl_t;

endpackage

// ===== rtl/core/sq_cell.sv =====
// One cell of the sorted chain: holds one entry and trades with its neighbors.
module sq_cell import sq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sq_ctrl_t                ctrl_i,
  input  logic signed [KeyW-1:0]  left_value_i,
  input  logic                    left_valid_i,
  input  logic                    left_lt_i,
  input  logic signed [KeyW-1:0]  right_value_i,
  input  logic                    right_valid_i,
  output logic signed [KeyW-1:0]  value_o,
  output logic                    valid_o,
  output logic                    lt_o,
  output logic [ReduceW-1:0]      reduce_o
);

  logic signed [KeyW-1:0] value_q, value_d;
  logic                   valid_q, valid_d;
  logic                   lt;
  logic                   last;

  assign lt   = valid_q && (value_q < ctrl_i.key);
  assign last = valid_q && !right_valid_i;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        // Cells below the key hold; the first one at or above takes the key,
        // the rest move up by one.
        if (!lt) begin
          if (left_lt_i) begin
            value_d = ctrl_i.key;
            valid_d = 1'b1;
          end else begin
            value_d = left_value_i;
            valid_d = left_valid_i;
          end
        end
      end
      CELL_SHIFT: begin
        value_d = right_value_i;
        valid_d = right_valid_i;
      end
      CELL_DELETE: begin
        // Close the gap left by the first matching entry.
        if (!lt) begin
          value_d = right_value_i;
          valid_d = right_valid_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o  = value_q;
  assign valid_o  = valid_q;
  assign lt_o     = lt;
  assign reduce_o = {valid_q && (value_q == ctrl_i.key),
                     last ? value_q : {KeyW{1'b0}}};

endmodule

// ===== rtl/core/sq_or_tree.sv =====
// Two-level registered OR tree over the per-cell words of the chain.
module sq_or_tree import sq_pkg::*; #(
  parameter int unsigned N = DefaultDepth,
  parameter int unsigned W = ReduceW
) (
  input  logic                  clk_i,
  input  logic [N-1:0][W-1:0]   data_i,
  output logic [W-1:0]          data_o
);

  localparam int unsigned NumGroups = (N + TreeGroup - 1) / TreeGroup;

  logic [NumGroups-1:0][W-1:0] grp_d, grp_q;
  logic [W-1:0]                root_d, root_q;

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < TreeGroup; k++) begin
        if (g * TreeGroup + k < N) begin
          grp_d[g] = grp_d[g] | data_i[g * TreeGroup + k];
        end
      end
    end
  end

  always_comb begin
    root_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      root_d = root_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    root_q <= root_d;
  end

  assign data_o = root_q;

endmodule

// ===== rtl/core/sq_ctrl.sv =====
// Command sequencer: drives the cell chain, tracks the count, builds results.
module sq_ctrl import sq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  sq_in_t                  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output sq_out_t                 out_data_o,
  output sq_ctrl_t                ctrl_o,
  input  logic signed [KeyW-1:0]  head_value_i,
  input  logic                    head_valid_i,
  input  logic [ReduceW-1:0]      tree_i
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e                 state_q, state_d;
  cmd_e                   cmd_q;
  logic signed [KeyW-1:0] key_q;
  status_e                status_q;
  logic [CntW-1:0]        count_q;
  logic                   settle_q;
  logic                   out_valid_q;
  sq_out_t                out_data_q;

  logic in_fire;
  logic out_free;
  logic full;
  logic empty;
  logic found;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (count_q == CntW'(DEPTH));
  assign empty    = (count_q == '0);
  assign found    = tree_i[KeyW];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.command == CMD_REMOVE) ? S_SETTLE : S_EXEC;
        end
      end
      S_EXEC:   state_d = S_SETTLE;
      S_SETTLE: begin
        if (!settle_q) begin
          state_d = (cmd_q == CMD_REMOVE) ? S_CHECK : S_DONE;
        end
      end
      S_CHECK:  state_d = found ? S_SETTLE : S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs toward the chain and the input side.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    ctrl_o.key = key_q;
    ctrl_o.op  = CELL_HOLD;
    unique case (state_q)
      S_EXEC: begin
        if (cmd_q == CMD_PUSH && !full) begin
          ctrl_o.op = CELL_INSERT;
        end else if (cmd_q == CMD_POP && !empty) begin
          ctrl_o.op = CELL_SHIFT;
        end
      end
      S_CHECK: begin
        if (found) begin
          ctrl_o.op = CELL_DELETE;
        end
      end
      S_IDLE, S_SETTLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      settle_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        settle_q <= 1'b1;
      end else if (state_q == S_EXEC) begin
        settle_q <= 1'b1;
        if (cmd_q == CMD_PUSH && !full) begin
          count_q <= count_q + 1'b1;
        end else if (cmd_q == CMD_POP && !empty) begin
          count_q <= count_q - 1'b1;
        end
      end else if (state_q == S_CHECK && found) begin
        settle_q <= 1'b1;
        count_q  <= count_q - 1'b1;
      end else if (state_q == S_SETTLE) begin
        settle_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= in_data_i.command;
      key_q    <= in_data_i.value;
      status_q <= (in_data_i.command == CMD_REMOVE) ? STAT_NO_MATCH : STAT_OK;
    end else if (state_q == S_EXEC) begin
      if (cmd_q == CMD_PUSH && full) begin
        status_q <= STAT_PUSH_FULL;
      end else if (cmd_q == CMD_POP && empty) begin
        status_q <= STAT_POP_EMPTY;
      end
    end else if (state_q == S_CHECK && found) begin
      status_q <= STAT_OK;
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q.smallest    <= head_valid_i ? head_value_i : '0;
      out_data_q.largest     <= tree_i[KeyW-1:0];
      out_data_q.entry_count <= CountW'(count_q);
      out_data_q.status      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_head_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i == !empty)
    else $error("front cell validity disagrees with entry count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_PUSH && !full) |=>
      count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the store");

  a_delete_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.op == CELL_DELETE) |-> (state_q == S_CHECK && !empty))
    else $error("delete issued without a stored match");
`endif

endmodule

// ===== rtl/core/sorted_queue_with_remove.sv =====
// Sorted queue with remove: top level with the cell chain, reduction tree and sequencer.
// Keeps up to DEPTH signed keys in ascending order in a chain of cells, one key per
// cell, and runs one command at a time. A remove deletes every matching key, closing
// one gap in the chain per step. After every change of the chain the two-stage
// registered OR tree that collects the back entry and the match flag from all cells
// must settle before it is read. A finished result sits in an output register, so
// the next command is taken while it waits.
module sorted_queue_with_remove import sq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sq_in_t   in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sq_out_t  out_data_o
);

  sq_ctrl_t                        ctrl;
  logic signed [KeyW-1:0]          cell_value [DEPTH];
  logic [DEPTH-1:0]                cell_valid;
  logic [DEPTH-1:0]                cell_lt;
  logic [DEPTH-1:0][ReduceW-1:0]   cell_reduce;
  logic [ReduceW-1:0]              tree;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KeyW-1:0] left_value;
    logic                   left_valid;
    logic                   left_lt;
    logic signed [KeyW-1:0] right_value;
    logic                   right_valid;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_valid = 1'b0;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    sq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .left_lt_i     (left_lt),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .lt_o          (cell_lt[i]),
      .reduce_o      (cell_reduce[i])
    );
  end

  sq_or_tree #(
    .N (DEPTH),
    .W (ReduceW)
  ) u_tree (
    .clk_i  (clk_i),
    .data_i (cell_reduce),
    .data_o (tree)
  );

  sq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .ctrl_o       (ctrl),
    .head_value_i (cell_value[0]),
    .head_valid_i (cell_valid[0]),
    .tree_i       (tree)
  );

endmodule

// ===== tb/sorted_queue_checker.sv =====
// Checker for the sorted queue: shadows the key store, predicts each result and compares.
module sorted_queue_checker import sq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  sq_in_t   in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  sq_out_t  out_data_i,
  output int       fail_count_o,
  output int       backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [KeyW-1:0] shadow_keys [DEPTH];
  int                     shadow_fill;
  sq_out_t                results_due [$];
  int                     mismatches;

  assign fail_count_o = mismatches;

  // Apply one command to the shadow store and return the result it should produce.
  function automatic sq_out_t apply_command(input sq_in_t item);
    sq_out_t res;
    int      pos;
    int      wr;
    res = '0;
    res.status = STAT_OK;
    case (item.command)
      CMD_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = STAT_PUSH_FULL;
        end else begin
          pos = 0;
          // Insert ahead of any equal keys.
          while (pos < shadow_fill && $signed(shadow_keys[pos]) < $signed(item.value)) pos++;
          for (int i = shadow_fill; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[pos] = item.value;
          shadow_fill++;
        end
      end
      CMD_POP: begin
        if (shadow_fill == 0) begin
          res.status = STAT_POP_EMPTY;
        end else begin
          for (int i = 1; i < shadow_fill; i++) shadow_keys[i-1] = shadow_keys[i];
          shadow_fill--;
        end
      end
      CMD_REMOVE: begin
        wr = 0;
        for (int rd = 0; rd < shadow_fill; rd++) begin
          if (shadow_keys[rd] != item.value) begin
            shadow_keys[wr] = shadow_keys[rd];
            wr++;
          end
        end
        if (wr == shadow_fill) res.status = STAT_NO_MATCH;
        else shadow_fill = wr;
      end
      default: ;
    endcase
    if (shadow_fill > 0) begin
      res.smallest = shadow_keys[0];
      res.largest  = shadow_keys[shadow_fill-1];
    end
    res.entry_count = CountW'(shadow_fill);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sq_out_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      results_due.delete();
      mismatches = 0;
      backlog_o <= 0;
    end else begin
      // Check the outgoing transfer against the oldest prediction before adding new ones.
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result with nothing pending: min %0d max %0d count %0d status %0d",
                     $realtime, $signed(out_data_i.smallest), $signed(out_data_i.largest),
                     out_data_i.entry_count, out_data_i.status);
        end else begin
          want = results_due.pop_front();
          if (out_data_i.smallest !== want.smallest || out_data_i.largest !== want.largest ||
              out_data_i.entry_count !== want.entry_count ||
              out_data_i.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: mismatch: expected min %0d max %0d count %0d status %0d, got min %0d max %0d count %0d status %0d",
                       $realtime, $signed(want.smallest), $signed(want.largest),
                       want.entry_count, want.status, $signed(out_data_i.smallest),
                       $signed(out_data_i.largest), out_data_i.entry_count,
                       out_data_i.status);
          end
        end
      end
      if (in_valid_i && in_ready_i) results_due.push_back(apply_command(in_data_i));
      backlog_o <= results_due.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the sorted queue testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench import sq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = DefaultDepth;
  localparam int          RandomOps = 400;

  logic    clk_i     = 1'b0;
  logic    rst_ni    = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  sq_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sq_out_t out_data;
  int      fail_count;
  int      backlog;

  int      burst_left = 1;
  int      stall_left = 0;

  always #1 clk_i = ~clk_i;

  sorted_queue_with_remove #(.DEPTH(Depth)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  sorted_queue_checker #(.DEPTH(Depth)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  // Receiver: runs of stalls, short ready runs and long stall-free stretches.
  always @(posedge clk_i) begin
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(1, 6);
      end else if (pick < 5) begin
        out_ready  <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end else begin
        out_ready  <= 1'b1;
        stall_left <= $urandom_range(1, 6);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Offer one command, hold it until the transfer, then pace the next burst.
  task automatic send_op(input cmd_e cmd, input logic signed [KeyW-1:0] key);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, value: key};
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Half from a small pool so pushes collide and removes hit; the rest spans every bit.
  function automatic logic signed [KeyW-1:0] pick_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return KeyW'($urandom_range(0, 7) - 4);
    if (pick < 7) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(KeyW-1){1'b0}}};
        1: return {1'b0, {(KeyW-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return KeyW'($urandom());
  endfunction

  // Weight commands by episode: 0 fills the store, 1 drains it, 2 is balanced.
  function automatic cmd_e pick_cmd(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (roll < 70) return CMD_PUSH;
        if (roll < 80) return CMD_POP;
        if (roll < 90) return CMD_REMOVE;
        return CMD_QUERY;
      end
      1: begin
        if (roll < 20) return CMD_PUSH;
        if (roll < 60) return CMD_POP;
        if (roll < 90) return CMD_REMOVE;
        return CMD_QUERY;
      end
      default: begin
        if (roll < 25) return CMD_PUSH;
        if (roll < 50) return CMD_POP;
        if (roll < 75) return CMD_REMOVE;
        return CMD_QUERY;
      end
    endcase
  endfunction

  initial begin
    int mode;
    int episode_left;
    cmd_e cmd;
    mode = 0;
    episode_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store corner cases.
    send_op(CMD_QUERY, '0);
    send_op(CMD_POP, '0);
    send_op(CMD_REMOVE, KeyW'(5));
    // Extremes and alternating bit patterns.
    send_op(CMD_PUSH, {1'b0, {(KeyW-1){1'b1}}});
    send_op(CMD_PUSH, {1'b1, {(KeyW-1){1'b0}}});
    send_op(CMD_PUSH, '0);
    send_op(CMD_PUSH, '1);
    send_op(CMD_PUSH, 32'h5555_5555);
    send_op(CMD_PUSH, 32'hAAAA_AAAA);
    send_op(CMD_QUERY, '1);
    // Fill with duplicates, overflow, then remove them all at once.
    repeat (Depth - 6) send_op(CMD_PUSH, KeyW'(7));
    send_op(CMD_PUSH, KeyW'(7));
    send_op(CMD_REMOVE, KeyW'(7));
    send_op(CMD_REMOVE, {1'b1, {(KeyW-1){1'b0}}});
    send_op(CMD_POP, '0);
    send_op(CMD_QUERY, '0);

    for (int n = 0; n < RandomOps; n++) begin
      if (episode_left == 0) begin
        mode = $urandom_range(0, 2);
        episode_left = $urandom_range(20, 60);
      end
      episode_left--;
      // Hold off once until the queue of outstanding results has drained.
      if (n == RandomOps / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (backlog != 0);
      end
      cmd = pick_cmd(mode);
      send_op(cmd, pick_key());
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && backlog == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
